@@ rtl/core/proportional_word_wrap_core_assert.svh @@
// ----------------------------------------------------------------------------
// proportional_word_wrap_core_assert.svh
// Assertion macros for the proportional word wrap core.
// ----------------------------------------------------------------------------
`ifndef PROPORTIONAL_WORD_WRAP_CORE_ASSERT_SVH
`define PROPORTIONAL_WORD_WRAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PWW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PWW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pww_pkg.sv @@
// ----------------------------------------------------------------------------
// pww_pkg
// Shared constants, character codes and glyph width table for the
// proportional word wrap core.
// ----------------------------------------------------------------------------
package pww_pkg;

    localparam int WORD_MAX_DEF = 32;
    localparam int POS_W        = 16;
    localparam int CHAR_W       = 8;
    localparam int GLYPH_W      = 4;

    localparam logic [POS_W-1:0] LINE_WIDTH_RST = 16'd226;
    localparam logic [POS_W-1:0] POS_SAT        = 16'hFFFF;

    // Special character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    typedef logic [GLYPH_W-1:0] glyph_w_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // Pixel width of each glyph, indexed by the low 7 bits of the byte
    localparam glyph_w_t PIX_WIDTH [128] = '{
        4'd0, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd8,
        4'd8, 4'd6, 4'd8, 4'd8, 4'd8, 4'd0, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd3, 4'd4, 4'd5, 4'd9, 4'd7, 4'd10, 4'd8, 4'd3,
        4'd6, 4'd6, 4'd7, 4'd8, 4'd4, 4'd7, 4'd3, 4'd6,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd3, 4'd4, 4'd5, 4'd7, 4'd5, 4'd7,
        4'd9, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6,
        4'd7, 4'd4, 4'd6, 4'd7, 4'd6, 4'd9, 4'd7, 4'd6,
        4'd7, 4'd6, 4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd10,
        4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd7,
        4'd4, 4'd5, 4'd6, 4'd5, 4'd5, 4'd5, 4'd4, 4'd5,
        4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd9, 4'd6, 4'd5,
        4'd6, 4'd5, 4'd6, 4'd5, 4'd4, 4'd6, 4'd6, 4'd8,
        4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd5, 4'd7, 4'd0
    };

    // Glyph width of a byte; the top bit is ignored
    function automatic glyph_w_t glyph_width(input char_t c);
        return PIX_WIDTH[c[6:0]];
    endfunction

endpackage

@@ rtl/core/proportional_word_wrap_core.sv @@
// ----------------------------------------------------------------------------
// proportional_word_wrap_core
// Greedy word wrap of a byte stream for a proportional font.
// ----------------------------------------------------------------------------
// Usage:
//   Input bytes arrive on in_valid/in_ready/in_char, one byte per beat.
//   Output bytes leave on out_valid/out_ready with out_char, out_last
//   (last beat caused by an input byte) and word_overflow (wrap decision
//   taken on a truncated word). cfg_wr_en/cfg_wr_data set line_width;
//   write it only while the core is idle.
// Timing:
//   A space that only becomes pending is taken in S_IDLE alone. A byte that
//   goes straight through passes S_EMITC; one held into the word buffer,
//   S_ADDW. A byte that ends a held word passes S_DECIDE for the space or
//   newline decision, S_SPADD when the space is kept, S_RD and S_WEMIT per
//   held byte (a registered read of the word store, a pass through the shared
//   saturating adder), S_FIN for the flush and S_EMITC if the byte is sent.
//   One output register decouples the receiver; while out_ready is low the
//   sequencer holds and in_ready stays low until the byte is finished.
// Reset:
//   rst_n clears position, pending space, word length and output valid, and
//   sets line_width to 226. The word store needs no clearing.
// ----------------------------------------------------------------------------
module proportional_word_wrap_core
    import pww_pkg::*;
#(
    parameter int WORD_MAX = WORD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        out_last,
    output logic        word_overflow,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    `include "proportional_word_wrap_core_assert.svh"

    localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
    localparam int LEN_W  = $clog2(WORD_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WORD_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDW,
        S_DECIDE,
        S_SPADD,
        S_RD,
        S_WEMIT,
        S_FIN,
        S_EMITC
    } state_t;

    state_t            state_reg, state_next;
    char_t             char_reg, char_next;
    logic              ovf_reg, ovf_next;
    pos_t              line_pos_reg, line_pos_next;
    pos_t              line_width_reg, line_width_next;
    logic              pending_reg, pending_next;
    logic [LEN_W-1:0]  word_len_reg, word_len_next;
    pos_t              word_pix_reg, word_pix_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    char_t             out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    char_t  in_c;
    char_t  rd_data;
    logic   mem_wr_en;
    logic   mem_rd_en;
    pos_t   alu_a;
    pos_t   alu_b;
    pos_t   alu_sum;
    logic   alu_reach;
    logic   slot_free;
    logic   char_is_space;
    logic   char_is_break;
    logic   last_idx;
    logic   emit;
    char_t  emit_char;
    logic   emit_last;
    logic   emit_ovf;

    // Held word store
    pww_word_mem #(
        .WORD_MAX (WORD_MAX),
        .ADDR_W   (ADDR_W)
    ) u_word_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (word_len_reg[ADDR_W-1:0]),
        .wr_data (char_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Shared saturating adder / width compare
    pww_sat_add u_sat_add (
        .a       (alu_a),
        .b       (alu_b),
        .limit   (line_width_reg),
        .sum_sat (alu_sum),
        .reach   (alu_reach)
    );

    assign in_c          = (in_char == CH_TAB) ? CH_SPACE : in_char;
    assign char_is_space = (char_reg == CH_SPACE);
    assign char_is_break = (char_reg == CH_LF) || (char_reg == CH_CR) ||
                           (char_reg == CH_NUL);
    assign last_idx      = ((LEN_W'(idx_reg) + LEN_W'(1)) == word_len_reg);
    assign slot_free     = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == S_IDLE);

    // Adder operand select per sequencer step
    always_comb
    begin
        alu_a = line_pos_reg;
        alu_b = POS_W'(glyph_width(char_reg));
        unique case (state_reg)
            S_ADDW:
            begin
                alu_a = word_pix_reg;
            end
            S_DECIDE:
            begin
                alu_b = word_pix_reg;
            end
            S_SPADD:
            begin
                alu_b = POS_W'(glyph_width(CH_SPACE));
            end
            S_WEMIT:
            begin
                alu_b = POS_W'(glyph_width(rd_data));
            end
            default:
            begin
                alu_b = POS_W'(glyph_width(char_reg));
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        char_next       = char_reg;
        ovf_next        = ovf_reg;
        line_pos_next   = line_pos_reg;
        line_width_next = cfg_wr_en ? cfg_wr_data : line_width_reg;
        pending_next    = pending_reg;
        word_len_next   = word_len_reg;
        word_pix_next   = word_pix_reg;
        idx_next        = idx_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        emit            = 1'b0;
        emit_char       = char_reg;
        emit_last       = 1'b0;
        emit_ovf        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next = in_c;
                    ovf_next  = 1'b0;
                    if (in_c == CH_SPACE)
                    begin
                        if (pending_reg)
                        begin
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    else if ((in_c == CH_LF) || (in_c == CH_CR) || (in_c == CH_NUL))
                    begin
                        state_next = pending_reg ? S_DECIDE : S_EMITC;
                    end
                    else if (pending_reg)
                    begin
                        if (word_len_reg >= LEN_FULL)
                        begin
                            ovf_next   = 1'b1;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            state_next = S_ADDW;
                        end
                    end
                    else
                    begin
                        state_next = S_EMITC;
                    end
                end
            end

            // Append a byte to the held word
            S_ADDW:
            begin
                mem_wr_en     = 1'b1;
                word_pix_next = alu_sum;
                word_len_next = word_len_reg + LEN_W'(1);
                state_next    = S_IDLE;
            end

            // Space or newline for the pending space
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = alu_reach ? CH_LF : CH_SPACE;
                    emit_last = (word_len_reg == '0) && char_is_space;
                    emit_ovf  = ovf_reg;
                    idx_next  = '0;
                    if (alu_reach)
                    begin
                        line_pos_next = '0;
                        state_next    = (word_len_reg == '0) ? S_FIN : S_RD;
                    end
                    else
                    begin
                        state_next = S_SPADD;
                    end
                end
            end

            S_SPADD:
            begin
                line_pos_next = alu_sum;
                state_next    = (word_len_reg == '0) ? S_FIN : S_RD;
            end

            S_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_WEMIT;
            end

            // Emit one held byte
            S_WEMIT:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    emit_char     = rd_data;
                    emit_last     = last_idx && char_is_space;
                    line_pos_next = alu_sum;
                    if (last_idx)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            // Word flushed; a new space becomes the pending one
            S_FIN:
            begin
                word_len_next = '0;
                word_pix_next = '0;
                pending_next  = char_is_space;
                state_next    = char_is_space ? S_IDLE : S_EMITC;
            end

            // The byte itself, always the last beat
            S_EMITC:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (char_is_break)
                    begin
                        line_pos_next = '0;
                    end
                    else
                    begin
                        line_pos_next = alu_sum;
                    end
                    if (char_reg == CH_NUL)
                    begin
                        pending_next  = 1'b0;
                        word_len_next = '0;
                        word_pix_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
            out_ovf_next   = emit_ovf;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            char_reg       <= CH_NUL;
            ovf_reg        <= 1'b0;
            line_pos_reg   <= '0;
            line_width_reg <= LINE_WIDTH_RST;
            pending_reg    <= 1'b0;
            word_len_reg   <= '0;
            word_pix_reg   <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= CH_NUL;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_reg       <= char_next;
            ovf_reg        <= ovf_next;
            line_pos_reg   <= line_pos_next;
            line_width_reg <= line_width_next;
            pending_reg    <= pending_next;
            word_len_reg   <= word_len_next;
            word_pix_reg   <= word_pix_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign out_last      = out_last_reg;
    assign word_overflow = out_ovf_reg;

    // Checks
    `PWW_ASSERT_NOW(a_word_needs_space, word_len_reg != '0, pending_reg,
        "held word without a pending space")
    `PWW_ASSERT_NOW(a_word_len_bound, 1'b1, word_len_reg <= LEN_FULL,
        "held word length beyond buffer size")
    `PWW_ASSERT_NOW(a_ovf_on_decision, out_valid_reg && out_ovf_reg,
        (out_char_reg == CH_LF) || (out_char_reg == CH_SPACE),
        "overflow flag on a beat other than a wrap decision")
    `PWW_ASSERT_NEXT(a_fin_clears_word, state_reg == S_FIN, word_len_reg == '0,
        "held word not cleared after flush")

endmodule

@@ rtl/core/pww_word_mem.sv @@
// ----------------------------------------------------------------------------
// pww_word_mem
// Held-word byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pww_word_mem
    import pww_pkg::*;
#(
    parameter int WORD_MAX = WORD_MAX_DEF,
    parameter int ADDR_W   = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  char_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output char_t             rd_data
);

    char_t mem [WORD_MAX];
    char_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pww_sat_add.sv @@
// ----------------------------------------------------------------------------
// pww_sat_add
// Shared arithmetic unit: 16-bit saturating add plus compare of the
// unsaturated sum against the line width.
// ----------------------------------------------------------------------------
module pww_sat_add
    import pww_pkg::*;
(
    input  pos_t a,
    input  pos_t b,
    input  pos_t limit,
    output pos_t sum_sat,
    output logic reach
);

    logic [POS_W:0] sum;

    // One wide add feeding both the saturation and the compare
    assign sum     = {1'b0, a} + {1'b0, b};
    assign sum_sat = sum[POS_W] ? POS_SAT : sum[POS_W-1:0];
    assign reach   = (sum >= {1'b0, limit});

endmodule
